@@ rtl/sst_pkg.sv @@
// sst_pkg: shared types, constants and the microprogram of the sparse set table.
// Used by sst_useq, sst_datapath and sparse_set_table. No dependencies.

package sst_pkg;

  // Default configuration and fixed field widths
  localparam int unsigned IdSpaceDef    = 1024;
  localparam int unsigned ValueWidthDef = 32;
  localparam int unsigned IdFieldW      = 16;
  localparam int unsigned ValFieldW     = 32;
  localparam int unsigned SizeW         = 11;
  localparam int unsigned UpcW          = 4;

  // Request opcodes
  typedef enum logic [1:0] {
    OP_SET = 2'd0,
    OP_GET = 2'd1,
    OP_DEL = 2'd2,
    OP_CLR = 2'd3
  } op_e;

  typedef struct packed {
    op_e                  op;
    logic [IdFieldW-1:0]  entity_id;
    logic [ValFieldW-1:0] value_in;
  } req_t;

  typedef struct packed {
    logic                 found;
    logic [ValFieldW-1:0] value_out;
    logic [SizeW-1:0]     size;
    logic                 out_of_range;
  } rsp_t;

  // Microprogram addresses
  typedef enum logic [UpcW-1:0] {
    U_INIT = 4'd0,
    U_IDLE = 4'd1,
    U_SLOT = 4'd2,
    U_HIT  = 4'd3,
    U_SET  = 4'd4,
    U_DEL1 = 4'd5,
    U_DEL2 = 4'd6,
    U_CLR  = 4'd7,
    U_DONE = 4'd8
  } upc_e;

  // Datapath action of one microword
  typedef enum logic [3:0] {
    ACT_NONE      = 4'd0,
    ACT_WIPE      = 4'd1,
    ACT_ACCEPT    = 4'd2,
    ACT_READ_SLOT = 4'd3,
    ACT_RESOLVE   = 4'd4,
    ACT_SET_WRITE = 4'd5,
    ACT_READ_LAST = 4'd6,
    ACT_MOVE_LAST = 4'd7,
    ACT_CLEAR     = 4'd8,
    ACT_EMIT      = 4'd9
  } act_e;

  // Sequencing mode of one microword
  typedef enum logic [2:0] {
    J_NEXT     = 3'd0,  // fall through
    J_GOTO     = 3'd1,  // unconditional jump to target
    J_WIPE     = 3'd2,  // hold until the sparse wipe is done
    J_WAIT_IN  = 3'd3,  // hold until a request arrives, then dispatch
    J_DISPATCH = 3'd4,  // branch on opcode and hit
    J_WAIT_OUT = 3'd5   // hold while the output register is blocked
  } jmp_e;

  typedef struct packed {
    logic in_ready;
    act_e act;
    jmp_e jmp;
    upc_e target;
  } ctrl_t;

  typedef struct packed {
    logic wipe_done;
    logic accept;
    logic req_clear;
    logic req_oor;
    op_e  op;
    logic hit;
    logic out_free;
  } stat_t;

  // Control store
  function automatic ctrl_t ucode_rom(input upc_e upc);
    ctrl_t w;
    unique case (upc)
      U_INIT: w = '{1'b0, ACT_WIPE,      J_WIPE,     U_IDLE};
      U_IDLE: w = '{1'b1, ACT_ACCEPT,    J_WAIT_IN,  U_SLOT};
      U_SLOT: w = '{1'b0, ACT_READ_SLOT, J_NEXT,     U_HIT};
      U_HIT:  w = '{1'b0, ACT_RESOLVE,   J_DISPATCH, U_DONE};
      U_SET:  w = '{1'b0, ACT_SET_WRITE, J_GOTO,     U_DONE};
      U_DEL1: w = '{1'b0, ACT_READ_LAST, J_NEXT,     U_DEL2};
      U_DEL2: w = '{1'b0, ACT_MOVE_LAST, J_GOTO,     U_DONE};
      U_CLR:  w = '{1'b0, ACT_CLEAR,     J_NEXT,     U_DONE};
      U_DONE: w = '{1'b0, ACT_EMIT,      J_WAIT_OUT, U_IDLE};
      default: w = '{1'b0, ACT_NONE,     J_GOTO,     U_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ rtl/sst_useq.sv @@
// sst_useq: microprogram counter and control store of the sparse set table.
// Depends on sst_pkg (ucode_rom, ctrl_t, stat_t).

module sst_useq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sst_pkg::stat_t stat_i,
  output sst_pkg::ctrl_t ctrl_o
);
  import sst_pkg::*;

  upc_e  upc_q, upc_d;
  ctrl_t word;

  // Fetch the current microword
  assign word   = ucode_rom(upc_q);
  assign ctrl_o = word;

  // Next microprogram address
  always_comb begin
    upc_d = upc_q;
    unique case (word.jmp)
      J_NEXT: upc_d = upc_e'(upc_q + UpcW'(1));
      J_GOTO: upc_d = word.target;
      J_WIPE: begin
        if (stat_i.wipe_done) upc_d = word.target;
      end
      J_WAIT_IN: begin
        if (stat_i.accept) begin
          priority if (stat_i.req_clear) upc_d = U_CLR;
          else if (stat_i.req_oor)       upc_d = U_DONE;
          else                           upc_d = word.target;
        end
      end
      J_DISPATCH: begin
        unique case (stat_i.op)
          OP_SET:         upc_d = U_SET;
          OP_DEL:         upc_d = stat_i.hit ? U_DEL1 : U_DONE;
          OP_GET, OP_CLR: upc_d = word.target;
        endcase
      end
      J_WAIT_OUT: begin
        if (stat_i.out_free) upc_d = word.target;
      end
      default: upc_d = U_IDLE;
    endcase
  end

  // Program counter, starts in the wipe loop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= U_INIT;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

@@ rtl/sst_datapath.sv @@
// sst_datapath: sparse index, dense id and dense value memories, entry count,
// working registers and the output register. Depends on sst_pkg.

module sst_datapath #(
  parameter int unsigned ID_SPACE    = sst_pkg::IdSpaceDef,
  parameter int unsigned VALUE_WIDTH = sst_pkg::ValueWidthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  sst_pkg::req_t  in_req_i,
  input  sst_pkg::ctrl_t ctrl_i,
  output sst_pkg::stat_t stat_o,
  input  logic           out_stall_i,
  output logic           out_valid_o,
  output sst_pkg::rsp_t  out_rsp_o
);
  import sst_pkg::*;

  localparam int unsigned IdW    = $clog2(ID_SPACE);
  localparam int unsigned CntW   = $clog2(ID_SPACE + 1);
  localparam int unsigned IdCmpW = IdFieldW + 1;

  // Memories
  logic [IdW-1:0]         sparse_mem   [ID_SPACE];
  logic [IdW-1:0]         dense_id_mem [ID_SPACE];
  logic [VALUE_WIDTH-1:0] dense_val_mem[ID_SPACE];

  logic [IdW-1:0]         sparse_rd_q, did_rd_q;
  logic [VALUE_WIDTH-1:0] dval_rd_q;

  // Working and control registers
  req_t                   req_q;
  logic [IdW-1:0]         slot_q;
  logic                   found_q, oor_q;
  logic [VALUE_WIDTH-1:0] vout_q;
  logic [CntW-1:0]        count_q, count_d;
  logic [IdW-1:0]         wipe_q, wipe_d;
  logic                   out_valid_q, out_valid_d;
  rsp_t                   out_rsp_q;

  // Memory port controls
  logic                   sp_we, di_we, dv_we;
  logic [IdW-1:0]         sp_wa, sp_wd, sp_ra, dn_wa, dn_ra, di_wd;
  logic [VALUE_WIDTH-1:0] dv_wd;

  logic                   accept, req_clear, req_oor, hit, out_free, set_grow;
  logic [IdW-1:0]         id_w, last_w;
  logic [VALUE_WIDTH-1:0] val_w;

  // Decoded status
  assign accept    = ctrl_i.in_ready && in_valid_i;
  assign req_clear = (in_req_i.op == OP_CLR);
  assign req_oor   = !req_clear && ({1'b0, in_req_i.entity_id} >= IdCmpW'(ID_SPACE));
  assign id_w      = req_q.entity_id[IdW-1:0];
  assign val_w     = VALUE_WIDTH'(req_q.value_in);
  assign hit       = (CntW'(slot_q) < count_q) && (did_rd_q == id_w);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign set_grow  = !found_q && (count_q < CntW'(ID_SPACE));
  assign last_w    = IdW'(count_q - CntW'(1));

  assign stat_o = '{
    wipe_done: (wipe_q == IdW'(ID_SPACE - 1)),
    accept:    accept,
    req_clear: req_clear,
    req_oor:   req_oor,
    op:        req_q.op,
    hit:       hit,
    out_free:  out_free
  };

  // Memory address and write selection per action
  always_comb begin
    sp_we = 1'b0;
    sp_wa = id_w;
    sp_wd = '0;
    sp_ra = id_w;
    di_we = 1'b0;
    dv_we = 1'b0;
    dn_wa = slot_q;
    dn_ra = slot_q;
    di_wd = id_w;
    dv_wd = val_w;
    unique case (ctrl_i.act)
      ACT_WIPE: begin
        sp_we = 1'b1;
        sp_wa = wipe_q;
      end
      ACT_ACCEPT:    sp_ra = in_req_i.entity_id[IdW-1:0];
      ACT_READ_SLOT: dn_ra = sparse_rd_q;
      ACT_SET_WRITE: begin
        if (found_q) begin
          dv_we = 1'b1;
        end else if (set_grow) begin
          di_we = 1'b1;
          dv_we = 1'b1;
          dn_wa = IdW'(count_q);
          sp_we = 1'b1;
          sp_wd = IdW'(count_q);
        end
      end
      ACT_READ_LAST: dn_ra = last_w;
      ACT_MOVE_LAST: begin
        // last entry fills the hole, its sparse slot follows
        di_we = 1'b1;
        dv_we = 1'b1;
        di_wd = did_rd_q;
        dv_wd = dval_rd_q;
        sp_we = 1'b1;
        sp_wa = did_rd_q;
        sp_wd = slot_q;
      end
      ACT_NONE, ACT_RESOLVE, ACT_CLEAR, ACT_EMIT: ;
      default: ;
    endcase
  end

  // Sparse index memory
  always_ff @(posedge clk_i) begin
    if (sp_we) sparse_mem[sp_wa] <= sp_wd;
    sparse_rd_q <= sparse_mem[sp_ra];
  end

  // Dense id memory
  always_ff @(posedge clk_i) begin
    if (di_we) dense_id_mem[dn_wa] <= di_wd;
    did_rd_q <= dense_id_mem[dn_ra];
  end

  // Dense value memory
  always_ff @(posedge clk_i) begin
    if (dv_we) dense_val_mem[dn_wa] <= dv_wd;
    dval_rd_q <= dense_val_mem[dn_ra];
  end

  // Next values of control registers
  always_comb begin
    count_d     = count_q;
    wipe_d      = wipe_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (ctrl_i.act)
      ACT_WIPE:      wipe_d = wipe_q + IdW'(1);
      ACT_SET_WRITE: if (set_grow) count_d = count_q + CntW'(1);
      ACT_MOVE_LAST: count_d = count_q - CntW'(1);
      ACT_CLEAR:     count_d = '0;
      ACT_EMIT:      if (out_free) out_valid_d = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      wipe_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      wipe_q      <= wipe_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers and result register
  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.act)
      ACT_ACCEPT: begin
        if (accept) begin
          req_q   <= in_req_i;
          found_q <= 1'b0;
          vout_q  <= '0;
          oor_q   <= req_oor;
        end
      end
      ACT_READ_SLOT: slot_q <= sparse_rd_q;
      ACT_RESOLVE: begin
        found_q <= hit;
        if (req_q.op == OP_SET) begin
          vout_q <= val_w;
        end else if (hit) begin
          vout_q <= dval_rd_q;
        end
      end
      ACT_EMIT: begin
        if (out_free) begin
          out_rsp_q <= '{found_q, ValFieldW'(vout_q), SizeW'(count_q), oor_q};
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

@@ rtl/sparse_set_table.sv @@
// sparse_set_table: top level of the sparse set id-to-value table.
// Depends on sst_pkg, sst_useq and sst_datapath.
//
// Usage: requests enter on in_valid_i/in_stall_o/in_req_i (op, entity_id,
// value_in); each request yields exactly one response on
// out_valid_o/out_stall_i/out_rsp_o (found, value_out, size, out_of_range).
// A transfer happens on a clock edge with valid high and stall low.
// One request is processed at a time by a microprogram stepping a single
// set of memory ports. Clear resets the count, out-of-range ids skip to the
// response, and get, set and delete read the sparse index, then the dense
// entry, and resolve the hit; set then writes and a hit delete moves the
// last entry. A new request is taken in the cycle after the response loads.
// Each step is bounded by one registered read of the sparse, dense id or
// dense value memory; a delete needs three dependent reads.
// The response sits in an output register, so the next request can be
// accepted while it waits; a stalled receiver holds the response and the
// table waits at the end of the following request until it is taken.
// After reset the sparse index is wiped, one entry a cycle, over all
// ID_SPACE entries; in_stall_o stays high until the wipe is done.

module sparse_set_table #(
  parameter int unsigned ID_SPACE    = sst_pkg::IdSpaceDef,
  parameter int unsigned VALUE_WIDTH = sst_pkg::ValueWidthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  sst_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output sst_pkg::rsp_t out_rsp_o
);
  import sst_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // Microprogram sequencer
  sst_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  // Memories and working registers
  sst_datapath #(
    .ID_SPACE    (ID_SPACE),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_req_i    (in_req_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o)
  );

  assign in_stall_o = !ctrl.in_ready;

  // Rejected ids report nothing found and no value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.out_of_range) |->
      (!out_rsp_o.found && (out_rsp_o.value_out == '0)))
    else $error("out-of-range response carries found or value");

  // Only one request in flight: stall right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted while another is in flight");

  // Reported size never exceeds the capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(out_rsp_o.size) <= int'(ID_SPACE)))
    else $error("reported size exceeds capacity");

endmodule

@@ bench/tb_top.sv @@
// tb_top: self-checking bench for the sparse set id-to-value table.
// Depends on sst_pkg and sparse_set_table. Keeps its own table model, drives
// requests with random gaps and backpressure, and checks every response.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sst_pkg::*;

  localparam int unsigned IdSpace    = IdSpaceDef;
  localparam int unsigned IdW        = $clog2(IdSpace);
  localparam int unsigned MaxGap     = 17;
  localparam int unsigned CycleLimit = 300000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  req_t in_req_i    = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_rsp_o;

  sparse_set_table u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  // Model of the table contents
  logic [IdW-1:0] sparse_slot [IdSpace];
  logic [IdW-1:0] dense_id    [IdSpace];
  logic [31:0]    dense_val   [IdSpace];
  logic [SizeW-1:0] live_count;

  rsp_t        pending_rsps[$];
  rsp_t        want;
  int unsigned fail_count   = 0;
  int unsigned cycle_count  = 0;
  bit          gaps_off     = 1'b0;
  int unsigned long_hold    = 0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Apply one request to the model and return the response it should give
  function automatic rsp_t apply_table_op(input req_t r);
    rsp_t           res;
    logic [IdW-1:0] id;
    logic [IdW-1:0] slot;
    logic [IdW-1:0] last_slot;
    logic [IdW-1:0] moved_id;
    logic           hit;
    res = '0;
    id  = r.entity_id[IdW-1:0];
    if (r.op == OP_CLR) begin
      live_count = '0;
    end else if (r.entity_id >= IdSpace) begin
      res.out_of_range = 1'b1;
    end else begin
      slot = sparse_slot[id];
      // a slot at or above the count, or holding another id, is stale
      hit = (SizeW'(slot) < live_count) && (dense_id[slot] == id);
      res.found = hit;
      case (r.op)
        OP_SET: begin
          if (!hit) begin
            slot            = live_count[IdW-1:0];
            dense_id[slot]  = id;
            sparse_slot[id] = slot;
            live_count      = live_count + 1'b1;
          end
          dense_val[slot] = r.value_in;
          res.value_out   = r.value_in;
        end
        OP_GET: begin
          if (hit) res.value_out = dense_val[slot];
        end
        OP_DEL: begin
          if (hit) begin
            // swap the last live entry into the hole
            last_slot             = IdW'(live_count - 1'b1);
            moved_id              = dense_id[last_slot];
            res.value_out         = dense_val[slot];
            dense_id[slot]        = moved_id;
            dense_val[slot]       = dense_val[last_slot];
            sparse_slot[moved_id] = slot;
            live_count            = live_count - 1'b1;
          end
        end
        default: ;
      endcase
    end
    res.size = live_count;
    return res;
  endfunction

  // Send one request after a random gap; record its response once accepted
  task automatic issue_request(input op_e op, input logic [15:0] id,
                               input logic [31:0] val);
    int unsigned gap;
    req_t        r;
    gap         = gaps_off ? 0 : $urandom_range(0, MaxGap);
    r.op        = op;
    r.entity_id = id;
    r.value_in  = val;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_req_i   <= r;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pending_rsps.insert(pending_rsps.size(), apply_table_op(r));
  endtask

  // Stop sending and wait until every response is back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_rsps.size() != 0);
  endtask

  function automatic logic [15:0] pick_id();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 16'($urandom_range(0, 23));
    if (sel < 85) return 16'($urandom_range(0, IdSpace - 1));
    if (sel < 95) return 16'($urandom_range(IdSpace, 65535));
    return 16'(IdSpace - 1 - $urandom_range(0, 3));
  endfunction

  function automatic op_e pick_op();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return OP_SET;
    if (sel < 68) return OP_GET;
    if (sel < 96) return OP_DEL;
    return OP_CLR;
  endfunction

  // Lookups and deletes on an empty table, clear with junk fields
  task automatic test_empty_table();
    issue_request(OP_CLR, 16'hFFFF, 32'hFFFF_FFFF);
    issue_request(OP_GET, 16'd0, 32'd0);
    issue_request(OP_DEL, 16'd0, 32'hFFFF_FFFF);
  endtask

  // Lowest and highest ids and values, insert then update
  task automatic test_set_get_extremes();
    issue_request(OP_SET, 16'd0, 32'd0);
    issue_request(OP_SET, 16'(IdSpace - 1), 32'hFFFF_FFFF);
    issue_request(OP_GET, 16'(IdSpace - 1), 32'd0);
    issue_request(OP_SET, 16'(IdSpace - 1), 32'h5A5A_A5A5);
    issue_request(OP_GET, 16'd0, 32'hFFFF_FFFF);
    issue_request(OP_GET, 16'd512, 32'd0);
  endtask

  // Ids beyond the table are rejected and change nothing
  task automatic test_out_of_range_ids();
    issue_request(OP_SET, 16'(IdSpace), 32'h1234_5678);
    issue_request(OP_GET, 16'hFFFF, 32'd0);
    issue_request(OP_DEL, 16'h8000, 32'd0);
    issue_request(OP_GET, 16'(IdSpace - 1), 32'd0);
  endtask

  // Delete with swap from the end, stale index afterwards, delete of last
  task automatic test_delete_swap();
    issue_request(OP_DEL, 16'd0, 32'd0);
    issue_request(OP_GET, 16'(IdSpace - 1), 32'd0);
    issue_request(OP_GET, 16'd0, 32'd0);
    issue_request(OP_DEL, 16'(IdSpace - 1), 32'd0);
    issue_request(OP_DEL, 16'(IdSpace - 1), 32'd0);
  endtask

  // Clear leaves stale entries that must read as absent
  task automatic test_clear();
    issue_request(OP_SET, 16'd7, 32'hCAFE_0007);
    issue_request(OP_SET, 16'd8, 32'hCAFE_0008);
    issue_request(OP_CLR, 16'd8, 32'd0);
    issue_request(OP_GET, 16'd8, 32'd0);
    issue_request(OP_SET, 16'd8, 32'h0000_0808);
    issue_request(OP_GET, 16'd7, 32'd0);
  endtask

  // Mixed random traffic: a small hot set of ids, the full range and beyond
  task automatic test_random_traffic(input int unsigned count, input bit no_gaps);
    gaps_off = no_gaps;
    repeat (count) issue_request(pick_op(), pick_id(), $urandom());
    gaps_off = 1'b0;
    wait_drained();
  endtask

  // Receiver holds off for a long stretch while requests keep coming
  task automatic test_output_backpressure();
    long_hold = 250;
    gaps_off  = 1'b1;
    repeat (30) issue_request(pick_op(), pick_id(), $urandom());
    gaps_off  = 1'b0;
    wait_drained();
  endtask

  // Receiver: random stall before each response, or a long hold on request
  initial begin
    int unsigned hold;
    forever begin
      if (long_hold > 0) begin
        hold      = long_hold;
        long_hold = 0;
      end else begin
        hold = gaps_off ? 0 : $urandom_range(0, MaxGap);
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  // Response checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_rsps.size() == 0) begin
        $error("response with no request outstanding: %p", out_rsp_o);
        fail_count++;
      end else begin
        want = pending_rsps.pop_front();
        if (out_rsp_o.found !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, out_rsp_o.found);
          fail_count++;
        end
        if (out_rsp_o.value_out !== want.value_out) begin
          $error("value_out: expected %0h, actual %0h", want.value_out, out_rsp_o.value_out);
          fail_count++;
        end
        if (out_rsp_o.size !== want.size) begin
          $error("size: expected %0d, actual %0d", want.size, out_rsp_o.size);
          fail_count++;
        end
        if (out_rsp_o.out_of_range !== want.out_of_range) begin
          $error("out_of_range: expected %0d, actual %0d", want.out_of_range,
                 out_rsp_o.out_of_range);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("** sparse_set_table: FAILED **");
    $finish;
  end

  // Test sequence
  initial begin
    rst_ni = 1'b0;
    for (int i = 0; i < IdSpace; i++) begin
      sparse_slot[i] = '0;
      dense_id[i]    = '0;
      dense_val[i]   = '0;
    end
    live_count = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_table();
    test_set_get_extremes();
    test_out_of_range_ids();
    test_delete_swap();
    test_clear();
    wait_drained();
    test_random_traffic(170, 1'b0);
    test_output_backpressure();
    test_random_traffic(100, 1'b1);
    test_random_traffic(80, 1'b0);

    wait_drained();
    repeat (16) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** sparse_set_table: PASSED **");
    end else begin
      $display("** sparse_set_table: FAILED **");
    end
    $finish;
  end

endmodule

@@ sparse_set_table.f @@
rtl/sst_pkg.sv
rtl/sst_useq.sv
rtl/sst_datapath.sv
rtl/sparse_set_table.sv
bench/tb_top.sv
